FILE: rtl/core/frl_pkg.sv
package frl_pkg;

    localparam int REQ_W   = 3;
    localparam int FRAME_W = 64;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 32;
    localparam int LEN_W   = 11;
    localparam int STEP_W  = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [LEN_W-1:0] FIU_RESET  = 11'd1024;
    localparam logic [CNT_W-1:0] SYNC_RESET = 32'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH    = 3'd0,
        REQ_NEWEST  = 3'd1,
        REQ_OLDEST  = 3'd2,
        REQ_RECOVER = 3'd3,
        REQ_CLEAR   = 3'd4
    } req_t;

    typedef enum logic {
        REG_FRAMES_IN_USE = 1'b0,
        REG_SYNC_INTERVAL = 1'b1
    } reg_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_RESP
    } state_t;

endpackage

FILE: rtl/core/frl_ram.sv
module frl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/frame_ring_logger_with_checkpoint_core.sv
// Frame ring logger with checkpoint.
// Command channel: pulse start with req_type, frame_in and frame_index while
// busy is low; the item is taken at that edge and busy rises next cycle.
// Result channel: done is high for exactly one cycle with ok, rd_frame,
// total_pushed and frames_held; the receiver cannot stall and must take it.
// Reads, recover, clear and unknown requests pass the request register, the RAM
// read and the result register; a push also runs the bit-serial 32-step
// remainder of the new count by sync_interval that decides the checkpoint.
// busy falls in the cycle done is shown, so a new item may be started while
// the result is on the ports. Frames live in one RAM with a registered read;
// only one item is in flight, so reads never overlap a pending write.
// Configuration: APB, frames_in_use at 0x0, sync_interval at 0x4; the user must
// write them only while idle, which the block itself does not enforce. Reset
// clears the write slot, counts and checkpoint and loads frames_in_use = 1024,
// sync_interval = 1; frame RAM contents are not cleared.
module frame_ring_logger_with_checkpoint_core #(
    parameter int SLOTS      = 1024,
    parameter int FRAME_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [frl_pkg::REQ_W-1:0]      req_type,
    input  logic [frl_pkg::FRAME_W-1:0]    frame_in,
    input  logic [frl_pkg::IDX_W-1:0]      frame_index,
    output logic                           done,
    output logic                           ok,
    output logic [frl_pkg::FRAME_W-1:0]    rd_frame,
    output logic [frl_pkg::CNT_W-1:0]      total_pushed,
    output logic [frl_pkg::LEN_W-1:0]      frames_held,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [frl_pkg::APB_AW-1:0]     paddr,
    input  logic [frl_pkg::APB_DW-1:0]     pwdata,
    output logic [frl_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    import frl_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = ((SW > LEN_W) ? SW : LEN_W) + 1;

    state_t state_reg, state_next;

    logic [LEN_W-1:0]      fiu_reg;
    logic [CNT_W-1:0]      sync_reg;

    logic [REQ_W-1:0]      req_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [IDX_W-1:0]      idx_reg;

    logic [SW-1:0]         ws_reg, ws_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SW-1:0]         saved_slot_reg, saved_slot_next;
    logic [CNT_W-1:0]      saved_count_reg, saved_count_next;
    logic                  okf_reg, okf_next;

    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      dvd_reg, dvd_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    logic                  done_reg;
    logic                  ok_reg;
    logic [FRAME_W-1:0]    rd_frame_reg;
    logic [CNT_W-1:0]      total_reg;
    logic [LEN_W-1:0]      held_reg;

    logic                  ram_we, ram_re;
    logic [SW-1:0]         ram_raddr;
    logic [FRAME_BITS-1:0] ram_rdata;

    logic [LEN_W-1:0]      ring_len;
    logic [LEN_W-1:0]      held_w;
    logic [CNT_W-1:0]      div_w;
    logic [CNT_W:0]        trial;
    logic                  trial_ge;
    logic [CNT_W-1:0]      rem_step;
    logic                  rd_hit;
    logic [CW-1:0]         age;
    logic [CW-1:0]         back;
    logic [CW-1:0]         rd_pos;
    logic [CW-1:0]         ws_inc;
    logic                  is_read;
    logic                  accept;
    logic                  apb_wr;

    // ring geometry
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            ring_len = LEN_W'(1);
        end
        else if (32'(fiu_reg) > 32'(SLOTS))
        begin
            ring_len = LEN_W'(SLOTS);
        end
        else
        begin
            ring_len = fiu_reg;
        end
        held_w = (count_reg < 32'(ring_len)) ? count_reg[LEN_W-1:0] : ring_len;
    end

    // remainder step
    assign div_w    = (sync_reg == '0) ? CNT_W'(1) : sync_reg;
    assign trial    = {rem_reg, dvd_reg[CNT_W-1]};
    assign trial_ge = trial >= {1'b0, div_w};
    assign rem_step = trial_ge ? CNT_W'(trial - {1'b0, div_w}) : trial[CNT_W-1:0];

    // read address
    assign is_read = (req_reg == REQ_NEWEST) || (req_reg == REQ_OLDEST);
    assign rd_hit  = CW'(idx_reg) < CW'(held_w);
    assign age     = (req_reg == REQ_OLDEST) ? CW'(held_w) - CW'(1) - CW'(idx_reg)
                                             : CW'(idx_reg);
    assign back    = age + CW'(1);
    assign rd_pos  = (CW'(ws_reg) >= back) ? CW'(ws_reg) - back
                                           : CW'(ring_len) - (back - CW'(ws_reg));
    assign ws_inc  = CW'(ws_reg) + CW'(1);

    assign accept  = start && !busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (req_reg == REQ_PUSH) ? ST_DIV : ST_RESP;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(CNT_W - 1))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and control
    always_comb
    begin
        ws_next          = ws_reg;
        count_next       = count_reg;
        saved_slot_next  = saved_slot_reg;
        saved_count_next = saved_count_reg;
        okf_next         = okf_reg;
        rem_next         = rem_reg;
        dvd_next         = dvd_reg;
        step_next        = step_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = rd_pos[SW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                okf_next = 1'b0;
                unique case (req_reg)
                    REQ_PUSH:
                    begin
                        ram_we     = 1'b1;
                        ws_next    = (ws_inc >= CW'(ring_len)) ? '0 : ws_inc[SW-1:0];
                        count_next = count_reg + CNT_W'(1);
                        dvd_next   = count_reg + CNT_W'(1);
                        rem_next   = '0;
                        step_next  = '0;
                        okf_next   = 1'b1;
                    end
                    REQ_NEWEST, REQ_OLDEST:
                    begin
                        ram_re   = rd_hit;
                        okf_next = rd_hit;
                    end
                    REQ_RECOVER:
                    begin
                        if (CW'(saved_slot_reg) < CW'(ring_len))
                        begin
                            ws_next    = saved_slot_reg;
                            count_next = saved_count_reg;
                            okf_next   = 1'b1;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        ws_next          = '0;
                        count_next       = '0;
                        saved_slot_next  = '0;
                        saved_count_next = '0;
                        okf_next         = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DIV:
            begin
                rem_next  = rem_step;
                dvd_next  = {dvd_reg[CNT_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if ((step_reg == STEP_W'(CNT_W - 1)) && (rem_step == '0))
                begin
                    saved_slot_next  = ws_reg;
                    saved_count_next = count_reg;
                end
            end
            ST_RESP:
            begin
            end
        endcase
    end

    frl_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (SLOTS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ws_reg),
        .wdata (frame_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ws_reg          <= '0;
            count_reg       <= '0;
            saved_slot_reg  <= '0;
            saved_count_reg <= '0;
            okf_reg         <= 1'b0;
            step_reg        <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ws_reg          <= ws_next;
            count_reg       <= count_next;
            saved_slot_reg  <= saved_slot_next;
            saved_count_reg <= saved_count_next;
            okf_reg         <= okf_next;
            step_reg        <= step_next;
            done_reg        <= (state_reg == ST_RESP);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (accept)
        begin
            req_reg   <= req_type;
            frame_reg <= frame_in[FRAME_BITS-1:0];
            idx_reg   <= frame_index;
        end
        if (state_reg == ST_RESP)
        begin
            ok_reg       <= okf_reg;
            rd_frame_reg <= (okf_reg && is_read) ? FRAME_W'(ram_rdata) : '0;
            total_reg    <= count_reg;
            held_reg     <= held_w;
        end
    end

    // configuration
    assign apb_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SYNC_INTERVAL) ? sync_reg : APB_DW'(fiu_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg  <= FIU_RESET;
            sync_reg <= SYNC_RESET;
        end
        else if (apb_wr)
        begin
            if (paddr[2] == REG_SYNC_INTERVAL)
            begin
                sync_reg <= pwdata;
            end
            else
            begin
                fiu_reg <= pwdata[LEN_W-1:0];
            end
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign ok           = ok_reg;
    assign rd_frame     = rd_frame_reg;
    assign total_pushed = total_reg;
    assign frames_held  = held_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while an item is still in work");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_held_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (CNT_W'(frames_held) <= total_pushed))
        else $error("frames_held exceeds total_pushed");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (rd_frame == '0))
        else $error("failed item returned a nonzero frame");

endmodule

FILE: tb/sv/tb_frame_ring_logger_with_checkpoint_core.sv
module tb_frame_ring_logger_with_checkpoint_core;
    import frl_pkg::*;

    localparam int NSLOT       = 1024;
    localparam int PLAN        = 0;
    localparam int LIVE        = 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;
    localparam int PH_ITEMS    = 80;
    localparam int NPHASE      = 6;
    localparam int SETTLE      = 40;

    localparam logic [REQ_W-1:0] REQ_NONE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_NONE_LAST  = 3'd7;

    localparam logic [APB_DW-1:0] PH_LEN  [NPHASE] = '{32'd7, 32'd2047, 32'd1, 32'd16, 32'd3,
                                                        32'd1000};
    localparam logic [APB_DW-1:0] PH_SYNC [NPHASE] = '{32'd3, 32'hFFFF_FFFF, 32'd1, 32'd2,
                                                        32'd7, 32'd0};
    localparam int PH_GAP [NPHASE] = '{0, 55, 19, 0, 55, 19};

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [FRAME_W-1:0] frame;
        logic [IDX_W-1:0]   idx;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] frame;
        logic [CNT_W-1:0]   total;
        logic [LEN_W-1:0]   held;
    } res_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    logic [REQ_W-1:0]   req_type    = '0;
    logic [FRAME_W-1:0] frame_in    = '0;
    logic [IDX_W-1:0]   frame_index = '0;
    logic               done;
    logic               ok;
    logic [FRAME_W-1:0] rd_frame;
    logic [CNT_W-1:0]   total_pushed;
    logic [LEN_W-1:0]   frames_held;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [APB_AW-1:0]  paddr       = '0;
    logic [APB_DW-1:0]  pwdata      = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    frame_ring_logger_with_checkpoint_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .frame_in     (frame_in),
        .frame_index  (frame_index),
        .done         (done),
        .ok           (ok),
        .rd_frame     (rd_frame),
        .total_pushed (total_pushed),
        .frames_held  (frames_held),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    logic [FRAME_W-1:0] ring_frames [2][NSLOT];
    bit                 ring_filled [2][NSLOT];
    int unsigned        wr_slot     [2];
    logic [CNT_W-1:0]   n_pushed    [2];
    int unsigned        ck_slot     [2];
    logic [CNT_W-1:0]   ck_count    [2];
    logic [LEN_W-1:0]   cfg_len  = FIU_RESET;
    logic [CNT_W-1:0]   cfg_sync = SYNC_RESET;

    cmd_t cmd_backlog [$];
    res_t due_results [$];
    cmd_t cmd_on_port;
    int   cmds_left      = 0;
    int   launch_gap_pct = 0;
    int   bad_results    = 0;
    int   cycles         = 0;

    initial
    begin
        for (int m = 0; m < 2; m++)
        begin
            wr_slot[m]  = 0;
            n_pushed[m] = '0;
            ck_slot[m]  = 0;
            ck_count[m] = '0;
        end
    end

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned ring_len();
        if (cfg_len == '0)
            return 1;
        if (cfg_len > NSLOT)
            return NSLOT;
        return int'(cfg_len);
    endfunction

    function automatic int unsigned frames_ready(int m);
        int unsigned n;
        n = ring_len();
        return (n_pushed[m] < n) ? int'(n_pushed[m]) : n;
    endfunction

    function automatic bit read_slot(int m, cmd_t c, output int unsigned pos);
        int unsigned h;
        int unsigned age;
        int unsigned ws;
        h   = frames_ready(m);
        ws  = wr_slot[m];
        pos = 0;
        if (c.idx >= h)
            return 1'b0;
        age = (c.kind == REQ_NEWEST) ? int'(c.idx) : h - 1 - int'(c.idx);
        if (ws >= age + 1)
            pos = ws - age - 1;
        else
            pos = ring_len() - (age + 1 - ws);
        return 1'b1;
    endfunction

    function automatic res_t ring_step(int m, cmd_t c);
        res_t        r;
        int unsigned n;
        int unsigned pos;
        int unsigned div;
        r = '0;
        n = ring_len();
        case (c.kind)
            REQ_PUSH:
            begin
                div = (cfg_sync == '0) ? 1 : cfg_sync;
                ring_frames[m][wr_slot[m]] = c.frame;
                ring_filled[m][wr_slot[m]] = 1'b1;
                wr_slot[m] = (wr_slot[m] + 1 >= n) ? 0 : wr_slot[m] + 1;
                n_pushed[m] = n_pushed[m] + 1'b1;
                if (n_pushed[m] % div == 0)
                begin
                    ck_slot[m]  = wr_slot[m];
                    ck_count[m] = n_pushed[m];
                end
                r.ok = 1'b1;
            end
            REQ_NEWEST, REQ_OLDEST:
            begin
                if (read_slot(m, c, pos))
                begin
                    r.ok    = 1'b1;
                    r.frame = ring_frames[m][pos];
                end
            end
            REQ_RECOVER:
            begin
                if (ck_slot[m] < n)
                begin
                    wr_slot[m]  = ck_slot[m];
                    n_pushed[m] = ck_count[m];
                    r.ok        = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                wr_slot[m]  = 0;
                n_pushed[m] = '0;
                ck_slot[m]  = 0;
                ck_count[m] = '0;
                r.ok        = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.total = n_pushed[m];
        r.held  = LEN_W'(frames_ready(m));
        return r;
    endfunction

    task automatic queue_cmd(logic [REQ_W-1:0] k, logic [FRAME_W-1:0] f,
                             logic [IDX_W-1:0] i);
        cmd_t        c;
        int unsigned pos;
        int unsigned h;
        int          tries;
        c.kind  = k;
        c.frame = f;
        c.idx   = i;
        h       = frames_ready(PLAN);
        tries   = 0;
        // steer reads away from slots that were never written
        while ((c.kind == REQ_NEWEST || c.kind == REQ_OLDEST) && read_slot(PLAN, c, pos)
               && !ring_filled[PLAN][pos])
        begin
            if (tries < 8)
                c.idx = IDX_W'($urandom_range(h - 1));
            else if (h < NSLOT)
                c.idx = IDX_W'($urandom_range(NSLOT - 1, h));
            else
                c.kind = REQ_PUSH;
            tries++;
        end
        void'(ring_step(PLAN, c));
        cmd_backlog.push_back(c);
        cmds_left++;
    endtask

    task automatic queue_random();
        int unsigned        h;
        int                 pick;
        logic [REQ_W-1:0]   k;
        logic [IDX_W-1:0]   i;
        h    = frames_ready(PLAN);
        pick = $urandom_range(99);
        if (h > 0 && $urandom_range(3) != 0)
            i = IDX_W'($urandom_range(h - 1));
        else
            i = IDX_W'($urandom_range(NSLOT - 1));
        if (pick < 42)
            k = REQ_PUSH;
        else if (pick < 62)
            k = REQ_NEWEST;
        else if (pick < 82)
            k = REQ_OLDEST;
        else if (pick < 89)
            k = REQ_RECOVER;
        else if (pick < 93)
            k = REQ_CLEAR;
        else
            k = REQ_W'($urandom_range(REQ_NONE_LAST, REQ_NONE_FIRST));
        queue_cmd(k, {$urandom, $urandom}, i);
    endtask

    task automatic write_reg(reg_sel_t r, logic [APB_DW-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_FRAMES_IN_USE)
            cfg_len = v[LEN_W-1:0];
        else
            cfg_sync = v;
    endtask

    task automatic drain();
        while (cmds_left != 0 || due_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_cmds
        cmd_t c;
        bit   taken;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                due_results.push_back(ring_step(LIVE, cmd_on_port));
                cmds_left--;
            end
            if (!start || taken)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= launch_gap_pct)
                begin
                    c           = cmd_backlog.pop_front();
                    cmd_on_port = c;
                    start       <= 1'b1;
                    req_type    <= c.kind;
                    frame_in    <= c.frame;
                    frame_index <= c.idx;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                bad_results++;
                if (bad_results <= MAX_SHOWN)
                    $display("unexpected result: ok=%0d frame=%h total=%0d held=%0d",
                             ok, rd_frame, total_pushed, frames_held);
            end
            else
            begin
                want = due_results.pop_front();
                if (ok !== want.ok || rd_frame !== want.frame || total_pushed !== want.total
                    || frames_held !== want.held)
                begin
                    bad_results++;
                    if (bad_results <= MAX_SHOWN)
                        $display({"result mismatch: expected ok=%0d frame=%h total=%0d held=%0d,",
                                  " got ok=%0d frame=%h total=%0d held=%0d"},
                                 want.ok, want.frame, want.total, want.held,
                                 ok, rd_frame, total_pushed, frames_held);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : run
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_cmd(REQ_PUSH, '0, '0);
        queue_cmd(REQ_PUSH, '1, '1);
        queue_cmd(REQ_PUSH, 64'h8000_0000_0000_0001, '0);
        queue_cmd(REQ_NEWEST, '0, 10'd0);
        queue_cmd(REQ_NEWEST, '0, 10'd2);
        queue_cmd(REQ_NEWEST, '0, 10'd3);
        queue_cmd(REQ_OLDEST, '0, 10'd0);
        queue_cmd(REQ_OLDEST, '0, 10'd2);
        queue_cmd(REQ_OLDEST, '1, '1);
        queue_cmd(REQ_NEWEST, '0, '1);
        queue_cmd(REQ_NONE_FIRST, '1, '1);
        queue_cmd(REQ_NONE_LAST, '0, '0);
        queue_cmd(REQ_RECOVER, '0, '0);
        queue_cmd(REQ_CLEAR, '0, '0);
        queue_cmd(REQ_NEWEST, '0, 10'd0);
        queue_cmd(REQ_RECOVER, '0, '0);
        queue_cmd(REQ_PUSH, 64'h0123_4567_89AB_CDEF, '0);
        drain();

        // shrink the ring below the checkpoint and the write slot
        write_reg(REG_FRAMES_IN_USE, '0);
        write_reg(REG_SYNC_INTERVAL, '0);
        queue_cmd(REQ_RECOVER, '0, '0);
        queue_cmd(REQ_PUSH, 64'hFEDC_BA98_7654_3210, '0);
        queue_cmd(REQ_NEWEST, '0, 10'd0);
        queue_cmd(REQ_OLDEST, '0, 10'd0);
        queue_cmd(REQ_RECOVER, '0, '0);
        drain();

        for (int p = 0; p < NPHASE; p++)
        begin
            write_reg(REG_FRAMES_IN_USE, PH_LEN[p]);
            write_reg(REG_SYNC_INTERVAL, PH_SYNC[p]);
            launch_gap_pct = PH_GAP[p];
            repeat (PH_ITEMS) queue_random();
            drain();
        end

        repeat (SETTLE) @(posedge clk);
        if (bad_results == 0 && due_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/frl_pkg.sv
rtl/core/frl_ram.sv
rtl/core/frame_ring_logger_with_checkpoint_core.sv
tb/sv/tb_frame_ring_logger_with_checkpoint_core.sv
